### rtl/ptq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared types and codes of the periodic timer queue.
// ----------------------------------------------------------------------------
package ptq_pkg;

  localparam int CMD_W  = 3;
  localparam int ID_W   = 4;
  localparam int KIND_W = 2;
  localparam int SLOT_W = 6;   // covers up to 64 slots
  localparam int ORD_W  = 16;

  localparam logic [ORD_W-1:0] ORD_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_POLL    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ARM_REL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ARM_ABS = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CANCEL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

  localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FINISH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ANSWER = 2'd2;

  typedef enum logic [2:0] {
    C_NOP,
    C_CLEAR,
    C_ARM_ORD,
    C_RANK_CLR,
    C_RANK_STEP,
    C_RANK_APPLY
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [SLOT_W-1:0]   sel;
    logic                b_armed;
    logic [ORD_W-1:0]    b_order;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_DIV,
    S_TAKE,
    S_RANK,
    S_APPLY,
    S_ORDER,
    S_FIRE,
    S_ANSWER
  } state_t;

endpackage

### rtl/ptq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_div
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ptq_div #(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  num_r, num_nxt;
  logic [W-1:0]  den_r, den_nxt;
  logic [W:0]    sh;

  always_comb begin
    sh       = {rem_r, num_r[W-1]};
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    if (go) begin
      cnt_nxt = '0;
      run_nxt = 1'b1;
      rem_nxt = '0;
      num_nxt = dividend;
      den_nxt = divisor;
    end else if (run_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = W'(sh - {1'b0, den_r});
      end else begin
        rem_nxt = sh[W-1:0];
      end
      num_nxt = {num_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### rtl/ptq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_cell
// One timer slot plus one stage of the earliest-deadline search chain.
// ----------------------------------------------------------------------------
module ptq_cell
  import ptq_pkg::*;
#(
  parameter int TIME_BITS = 48,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctl_t            ctl,
  input  logic [TIME_BITS-1:0] wdl,
  input  logic [TIME_BITS-1:0] wper,
  input  logic                 ci_valid,
  input  logic [TIME_BITS-1:0] ci_dl,
  input  logic [ORD_W-1:0]     ci_ord,
  input  logic [SLOT_W-1:0]    ci_id,
  output logic                 co_valid,
  output logic [TIME_BITS-1:0] co_dl,
  output logic [ORD_W-1:0]     co_ord,
  output logic [SLOT_W-1:0]    co_id,
  output logic                 st_armed,
  output logic [TIME_BITS-1:0] st_dl,
  output logic [TIME_BITS-1:0] st_per,
  output logic [ORD_W-1:0]     st_order
);
  logic                 armed_r, armed_nxt;
  logic [TIME_BITS-1:0] dl_r, dl_nxt;
  logic [TIME_BITS-1:0] per_r, per_nxt;
  logic [ORD_W-1:0]     ord_r, ord_nxt;
  logic [SLOT_W-1:0]    rank_r, rank_nxt;
  logic                 cv_r;
  logic [TIME_BITS-1:0] cdl_r;
  logic [ORD_W-1:0]     cord_r;
  logic [SLOT_W-1:0]    cid_r;
  logic                 mine, take_own;

  assign mine = (ctl.sel == SLOT_W'(IDX));

  always_comb begin
    armed_nxt = armed_r;
    dl_nxt    = dl_r;
    per_nxt   = per_r;
    ord_nxt   = ord_r;
    rank_nxt  = rank_r;
    case (ctl.op)
      C_CLEAR: begin
        if (mine) begin
          armed_nxt = 1'b0;
          dl_nxt    = '0;
          per_nxt   = '0;
        end
      end
      C_ARM_ORD: begin
        if (mine) begin
          armed_nxt = 1'b1;
          dl_nxt    = wdl;
          per_nxt   = wper;
          ord_nxt   = ctl.b_order;
        end
      end
      C_RANK_CLR: rank_nxt = '0;
      C_RANK_STEP: begin
        if (ctl.b_armed && ctl.b_order < ord_r) rank_nxt = rank_r + 1'b1;
      end
      C_RANK_APPLY: begin
        if (armed_r) ord_nxt = ORD_W'(rank_r);
      end
      default: ;
    endcase
  end

  // keep the incoming candidate on a full tie: it comes from a lower slot
  assign take_own = armed_r && (!ci_valid || dl_r < ci_dl ||
                                (dl_r == ci_dl && ord_r < ci_ord));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      cv_r    <= 1'b0;
      dl_r    <= '0;
      per_r   <= '0;
      ord_r   <= '0;
    end else begin
      armed_r <= armed_nxt;
      cv_r    <= take_own | ci_valid;
      dl_r    <= dl_nxt;
      per_r   <= per_nxt;
      ord_r   <= ord_nxt;
    end
    rank_r <= rank_nxt;
    cdl_r  <= take_own ? dl_r : ci_dl;
    cord_r <= take_own ? ord_r : ci_ord;
    cid_r  <= take_own ? SLOT_W'(IDX) : ci_id;
  end

  assign co_valid = cv_r;
  assign co_dl    = cdl_r;
  assign co_ord   = cord_r;
  assign co_id    = cid_r;
  assign st_armed = armed_r;
  assign st_dl    = dl_r;
  assign st_per   = per_r;
  assign st_order = ord_r;

endmodule

### rtl/periodic_timer_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_queue_top
// Timer slots in a chain of cells; poll fires due timers in deadline order.
// ----------------------------------------------------------------------------
// Cancel, query and bad requests go straight to the answer; an arm passes the
// divider first when an absolute start is aligned to the period grid.
// Poll: one search of the cell chain per result, one result per fired timer
// and one for the finish; a periodic rearm passes the divider first.
// Any order take first renumbers the orders when the order counter is full.
// Synchronous reset disarms every slot; one request at a time; no result stall.
module periodic_timer_queue_top
  import ptq_pkg::*;
#(
  parameter int TIMER_SLOTS = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [CMD_W-1:0]            in_cmd,
  input  logic [ID_W-1:0]             in_timer_id,
  input  logic [TIME_BITS-1:0]        in_now_ms,
  input  logic [TIME_BITS-1:0]        in_interval_ms,
  input  logic [TIME_BITS-1:0]        in_start_ms,
  input  logic                        in_periodic,
  output logic                        out_valid,
  output logic [KIND_W-1:0]           out_kind,
  output logic [ID_W-1:0]             out_fired_id,
  output logic signed [TIME_BITS:0]   out_delay_ms,
  output logic                        out_last
);
  localparam int TB    = TIME_BITS;
  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW    = $clog2(TIMER_SLOTS + 1);
  localparam logic [CW-1:0] LAST_SLOT = CW'(TIMER_SLOTS - 1);
  localparam logic [CW-1:0] ALL_SLOTS = CW'(TIMER_SLOTS);

  state_t               state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic [TB-1:0]        now_r, now_nxt;
  logic                 bad_r, bad_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]    best_r, best_nxt;
  logic [TB-1:0]        wdl_r, wdl_nxt;
  logic [TB-1:0]        wper_r, wper_nxt;
  logic [ORD_W-1:0]     counter_r, counter_nxt;
  logic [ORD_W-1:0]     newcnt_r, newcnt_nxt;
  logic                 ov_r, ov_nxt;
  logic [KIND_W-1:0]    ok_r, ok_nxt;
  logic [ID_W-1:0]      oid_r, oid_nxt;
  logic [TB:0]          od_r, od_nxt;
  logic                 ol_r, ol_nxt;

  cell_ctl_t            ctl;
  logic                 div_go, div_done;
  logic [TB-1:0]        div_a, div_d, div_rem;

  logic                 ch_valid [TIMER_SLOTS+1];
  logic [TB-1:0]        ch_dl    [TIMER_SLOTS+1];
  logic [ORD_W-1:0]     ch_ord   [TIMER_SLOTS+1];
  logic [SLOT_W-1:0]    ch_id    [TIMER_SLOTS+1];
  logic                 st_armed [TIMER_SLOTS];
  logic [TB-1:0]        st_dl    [TIMER_SLOTS];
  logic [TB-1:0]        st_per   [TIMER_SLOTS];
  logic [ORD_W-1:0]     st_order [TIMER_SLOTS];

  assign ch_valid[0] = 1'b0;
  assign ch_dl[0]    = '0;
  assign ch_ord[0]   = '0;
  assign ch_id[0]    = '0;

  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
    ptq_cell #(.TIME_BITS(TB), .IDX(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wdl      (wdl_r),
      .wper     (wper_r),
      .ci_valid (ch_valid[g]),
      .ci_dl    (ch_dl[g]),
      .ci_ord   (ch_ord[g]),
      .ci_id    (ch_id[g]),
      .co_valid (ch_valid[g+1]),
      .co_dl    (ch_dl[g+1]),
      .co_ord   (ch_ord[g+1]),
      .co_id    (ch_id[g+1]),
      .st_armed (st_armed[g]),
      .st_dl    (st_dl[g]),
      .st_per   (st_per[g]),
      .st_order (st_order[g])
    );
  end

  ptq_div #(.W(TB)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .rem      (div_rem)
  );

  // chain end and per-slot lookups
  logic                 e_valid;
  logic [TB-1:0]        e_dl;
  logic [SLOT_W-1:0]    e_id;
  logic [TB-1:0]        e_per;
  logic [IDX_W-1:0]     q_idx, r_idx;
  logic                 q_armed;
  logic [TB-1:0]        q_dl;
  logic [TB:0]          in_sum, step_sum, sum;
  logic [TB-1:0]        in_gap, step;
  logic                 abs_align, id_bad, cmd_bad;

  assign e_valid = ch_valid[TIMER_SLOTS];
  assign e_dl    = ch_dl[TIMER_SLOTS];
  assign e_id    = ch_id[TIMER_SLOTS];
  assign e_per   = st_per[e_id[IDX_W-1:0]];
  assign q_idx   = IDX_W'(id_r);
  assign q_armed = st_armed[q_idx];
  assign q_dl    = st_dl[q_idx];
  assign r_idx   = cnt_r[IDX_W-1:0];

  assign in_sum    = {1'b0, in_now_ms} + {1'b0, in_interval_ms};
  assign in_gap    = in_now_ms - in_interval_ms;
  assign abs_align = (in_interval_ms <= in_now_ms) && (in_start_ms <= in_gap);
  assign id_bad    = (32'(in_timer_id) >= TIMER_SLOTS);
  assign cmd_bad   = (in_cmd > CMD_QUERY);
  assign step      = wper_r - div_rem;
  assign step_sum  = {1'b0, now_r} + {1'b0, step};
  assign sum       = step_sum;

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    id_nxt      = id_r;
    now_nxt     = now_r;
    bad_nxt     = bad_r;
    cnt_nxt     = cnt_r;
    best_nxt    = best_r;
    wdl_nxt     = wdl_r;
    wper_nxt    = wper_r;
    counter_nxt = counter_r;
    newcnt_nxt  = newcnt_r;
    ov_nxt      = 1'b0;
    ok_nxt      = ok_r;
    oid_nxt     = oid_r;
    od_nxt      = od_r;
    ol_nxt      = ol_r;
    ctl         = '{op: C_NOP, sel: '0, b_armed: 1'b0, b_order: '0};
    div_go      = 1'b0;
    div_a       = now_r - e_dl;
    div_d       = e_per;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt  = in_cmd;
          id_nxt   = in_timer_id;
          now_nxt  = in_now_ms;
          bad_nxt  = cmd_bad || id_bad;
          cnt_nxt  = '0;
          ctl.sel  = SLOT_W'(in_timer_id);
          if (in_cmd == CMD_POLL) begin
            state_nxt = S_SEARCH;
          end else if (cmd_bad || id_bad) begin
            state_nxt = S_ANSWER;
          end else if (in_cmd == CMD_ARM_REL) begin
            ctl.op    = C_CLEAR;
            wdl_nxt   = in_sum[TB] ? '1 : in_sum[TB-1:0];
            wper_nxt  = (in_periodic && in_interval_ms != '0) ? in_interval_ms : '0;
            state_nxt = S_TAKE;
          end else if (in_cmd == CMD_ARM_ABS) begin
            ctl.op   = C_CLEAR;
            wper_nxt = in_interval_ms;
            if (abs_align && in_interval_ms != '0) begin
              div_go    = 1'b1;
              div_a     = in_now_ms - in_start_ms;
              div_d     = in_interval_ms;
              state_nxt = S_DIV;
            end else begin
              wdl_nxt   = abs_align ? in_now_ms : in_start_ms;
              state_nxt = S_TAKE;
            end
          end else if (in_cmd == CMD_CANCEL) begin
            ctl.op    = C_CLEAR;
            state_nxt = S_ANSWER;
          end else begin
            state_nxt = S_ANSWER;
          end
        end
      end
      S_SEARCH: begin
        if (cnt_r != ALL_SLOTS) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (!e_valid) begin
          ov_nxt = 1'b1; ok_nxt = KIND_FINISH; oid_nxt = '0; od_nxt = '1; ol_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (e_dl > now_r) begin
          ov_nxt = 1'b1; ok_nxt = KIND_FINISH; oid_nxt = '0; ol_nxt = 1'b1;
          od_nxt = {1'b0, e_dl - now_r};
          state_nxt = S_IDLE;
        end else begin
          best_nxt = e_id;
          if (e_per != '0) begin
            div_go    = 1'b1;
            wper_nxt  = e_per;
            state_nxt = S_DIV;
          end else begin
            ctl.op    = C_CLEAR;
            ctl.sel   = e_id;
            state_nxt = S_FIRE;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (cmd_r == CMD_POLL) begin
            if (sum[TB]) begin
              // next period point passes the largest time
              ctl.op    = C_CLEAR;
              ctl.sel   = best_r;
              state_nxt = S_FIRE;
            end else begin
              wdl_nxt   = sum[TB-1:0];
              state_nxt = S_TAKE;
            end
          end else begin
            wdl_nxt   = now_r - div_rem;
            state_nxt = S_TAKE;
          end
        end
      end
      S_TAKE: begin
        if (counter_r == ORD_MAX) begin
          ctl.op     = C_RANK_CLR;
          cnt_nxt    = '0;
          newcnt_nxt = '0;
          state_nxt  = S_RANK;
        end else begin
          state_nxt = S_ORDER;
        end
      end
      S_RANK: begin
        ctl.op      = C_RANK_STEP;
        ctl.b_armed = st_armed[r_idx];
        ctl.b_order = st_order[r_idx];
        newcnt_nxt  = newcnt_r + ORD_W'(st_armed[r_idx]);
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == LAST_SLOT) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        ctl.op      = C_RANK_APPLY;
        counter_nxt = newcnt_r;
        state_nxt   = S_ORDER;
      end
      S_ORDER: begin
        ctl.op      = C_ARM_ORD;
        ctl.sel     = (cmd_r == CMD_POLL) ? best_r : SLOT_W'(id_r);
        ctl.b_order = counter_r;
        counter_nxt = counter_r + 1'b1;
        state_nxt   = (cmd_r == CMD_POLL) ? S_FIRE : S_ANSWER;
      end
      S_FIRE: begin
        ov_nxt = 1'b1; ok_nxt = KIND_FIRE; oid_nxt = ID_W'(best_r); od_nxt = '0;
        ol_nxt = 1'b0;
        cnt_nxt   = '0;
        state_nxt = S_SEARCH;
      end
      S_ANSWER: begin
        ov_nxt = 1'b1; ok_nxt = KIND_ANSWER; oid_nxt = id_r; ol_nxt = 1'b1;
        if (bad_r || !q_armed) od_nxt = '1;
        else if (now_r >= q_dl) od_nxt = '0;
        else od_nxt = {1'b0, q_dl - now_r};
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      counter_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      counter_r <= counter_nxt;
      ov_r      <= ov_nxt;
    end
    cmd_r    <= cmd_nxt;
    id_r     <= id_nxt;
    now_r    <= now_nxt;
    bad_r    <= bad_nxt;
    cnt_r    <= cnt_nxt;
    best_r   <= best_nxt;
    wdl_r    <= wdl_nxt;
    wper_r   <= wper_nxt;
    newcnt_r <= newcnt_nxt;
    ok_r     <= ok_nxt;
    oid_r    <= oid_nxt;
    od_r     <= od_nxt;
    ol_r     <= ol_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = ov_r;
  assign out_kind     = ok_r;
  assign out_fired_id = oid_r;
  assign out_delay_ms = od_r;
  assign out_last     = ol_r;

  // a request only completes together with its final result
  a_done_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid && out_last)
    else $error("request ended without a final result");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("final result while still busy");

  a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_kind == KIND_FIRE)
    else $error("non-final result is not a fired timer");

  a_fire_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FIRE |-> busy)
    else $error("poll stopped after a fired timer");

endmodule

### tb/periodic_timer_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_queue_top_tb
// Self-checking bench for the periodic timer queue: directed requests cover
// every command, time extremes, absolute alignment and tie order, then
// random traffic. An internal predictor tracks all slots.
// ----------------------------------------------------------------------------
module periodic_timer_queue_top_tb;
  import ptq_pkg::*;

  localparam int SLOTS = 16;
  localparam int TBITS = 48;
  localparam logic [63:0] TMAX = (64'd1 << TBITS) - 1;
  localparam logic [48:0] NO_DELAY = '1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [48:0]       dly;
    logic              last;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] in_cmd = '0;
  logic [ID_W-1:0] in_timer_id = '0;
  logic [TBITS-1:0] in_now_ms = '0;
  logic [TBITS-1:0] in_interval_ms = '0;
  logic [TBITS-1:0] in_start_ms = '0;
  logic in_periodic = 1'b0;
  logic out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [ID_W-1:0] out_fired_id;
  logic signed [TBITS:0] out_delay_ms;
  logic out_last;

  periodic_timer_queue_top #(.TIMER_SLOTS(SLOTS), .TIME_BITS(TBITS)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_timer_id(in_timer_id), .in_now_ms(in_now_ms),
    .in_interval_ms(in_interval_ms), .in_start_ms(in_start_ms),
    .in_periodic(in_periodic), .out_valid(out_valid), .out_kind(out_kind),
    .out_fired_id(out_fired_id), .out_delay_ms(out_delay_ms), .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted slot state
  logic [63:0] slot_deadline [SLOTS];
  logic [63:0] slot_period [SLOTS];
  logic        slot_armed [SLOTS];
  logic [15:0] slot_order [SLOTS];
  logic [15:0] order_counter;

  timer_result_t pending_results[$];
  int mismatches = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int fires_seen = 0;
  bit idle_enable = 1'b1;
  logic [63:0] clock_ms = 0;

  function automatic void renumber_orders();
    bit used [SLOTS];
    int best;
    logic [15:0] next_ord = 0;
    for (int i = 0; i < SLOTS; i++) used[i] = 1'b0;
    forever begin
      best = -1;
      for (int i = 0; i < SLOTS; i++)
        if (slot_armed[i] && !used[i] && (best < 0 || slot_order[i] < slot_order[best]))
          best = i;
      if (best < 0) break;
      used[best] = 1'b1;
      slot_order[best] = next_ord;
      next_ord++;
    end
    order_counter = next_ord;
  endfunction

  function automatic void assign_order(int s);
    if (order_counter == 16'hFFFF) renumber_orders();
    slot_order[s] = order_counter;
    order_counter++;
  endfunction

  function automatic void clear_timer(int s);
    slot_armed[s] = 1'b0;
    slot_period[s] = 0;
    slot_deadline[s] = 0;
  endfunction

  function automatic void push_result(logic [1:0] k, logic [3:0] id, logic [48:0] d,
                                      logic l);
    timer_result_t r;
    r.kind = k; r.id = id; r.dly = d; r.last = l;
    pending_results.push_back(r);
  endfunction

  // Computes the results of one accepted request and updates the slot state.
  function automatic void predict_request(logic [2:0] cmd, logic [3:0] id,
      logic [63:0] now, logic [63:0] ival, logic [63:0] st, logic per);
    int best;
    int s;
    logic [63:0] step;
    logic [48:0] d;
    s = id;
    if (cmd == CMD_POLL) begin
      forever begin
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_armed[i]) continue;
          if (best < 0 || slot_deadline[i] < slot_deadline[best] ||
              (slot_deadline[i] == slot_deadline[best] && slot_order[i] < slot_order[best]))
            best = i;
        end
        if (best < 0) begin
          push_result(KIND_FINISH, 0, NO_DELAY, 1'b1);
          return;
        end
        if (slot_deadline[best] > now) begin
          push_result(KIND_FINISH, 0, 49'(slot_deadline[best] - now), 1'b1);
          return;
        end
        if (slot_period[best] != 0) begin
          step = slot_period[best] - ((now - slot_deadline[best]) % slot_period[best]);
          if (step > TMAX - now) clear_timer(best);
          else begin
            slot_deadline[best] = now + step;
            assign_order(best);
          end
        end else clear_timer(best);
        push_result(KIND_FIRE, 4'(best), 0, 1'b0);
      end
    end
    if (cmd > CMD_QUERY || s >= SLOTS) begin
      push_result(KIND_ANSWER, id, NO_DELAY, 1'b1);
      return;
    end
    if (cmd == CMD_ARM_REL) begin
      clear_timer(s);
      slot_deadline[s] = (ival > TMAX - now) ? TMAX : now + ival;
      slot_period[s] = (per && ival != 0) ? ival : 0;
      slot_armed[s] = 1'b1;
      assign_order(s);
    end else if (cmd == CMD_ARM_ABS) begin
      if (ival <= now && st <= now - ival)
        st = (ival != 0) ? now - ((now - st) % ival) : now;
      clear_timer(s);
      slot_deadline[s] = st;
      slot_period[s] = ival;
      slot_armed[s] = 1'b1;
      assign_order(s);
    end else if (cmd == CMD_CANCEL) begin
      clear_timer(s);
    end
    if (!slot_armed[s]) d = NO_DELAY;
    else if (now >= slot_deadline[s]) d = 0;
    else d = 49'(slot_deadline[s] - now);
    push_result(KIND_ANSWER, id, d, 1'b1);
  endfunction

  // Holds start high until the request is taken; it stays high but for random gaps.
  task automatic send_request(logic [2:0] cmd, logic [3:0] id, logic [63:0] now,
      logic [63:0] ival = 0, logic [63:0] st = 0, logic per = 1'b0);
    start <= 1'b1;
    in_cmd <= cmd;
    in_timer_id <= id;
    in_now_ms <= now[TBITS-1:0];
    in_interval_ms <= ival[TBITS-1:0];
    in_start_ms <= st[TBITS-1:0];
    in_periodic <= per;
    do @(posedge clk); while (busy !== 1'b0);
    predict_request(cmd, id, now & TMAX, ival & TMAX, st & TMAX, per);
    requests_sent++;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand_time();
    return {$urandom, $urandom} & TMAX;
  endfunction

  always @(posedge clk) begin
    timer_result_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_kind == KIND_FIRE) fires_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d id %0d delay %0d last %0b",
                   out_kind, out_fired_id, out_delay_ms, out_last);
      end else begin
        want = pending_results.pop_front();
        if (out_kind !== want.kind || out_fired_id !== want.id ||
            out_delay_ms !== want.dly || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind %0d id %0d delay %0d last %0b, got %0d %0d %0d %0b",
                     want.kind, want.id, $signed(want.dly), want.last,
                     out_kind, out_fired_id, out_delay_ms, out_last);
        end
      end
    end
  end

  task automatic test_basic_commands();
    send_request(CMD_POLL, 0, 100);
    send_request(CMD_QUERY, 3, 100);
    send_request(CMD_ARM_REL, 3, 100, 50, 0, 1'b0);
    send_request(CMD_ARM_REL, 4, 100, 20, 0, 1'b1);
    send_request(CMD_ARM_REL, 5, 100, 0, 0, 1'b1);
    send_request(CMD_QUERY, 3, 120);
    send_request(CMD_POLL, 0, 100);
    send_request(CMD_POLL, 0, 165);
    send_request(CMD_CANCEL, 4, 170);
    send_request(CMD_QUERY, 4, 170);
    send_request(3'd5, 7, 170);
    send_request(3'd6, 15, 170);
    send_request(3'd7, 0, 170);
  endtask

  task automatic test_absolute_arm();
    send_request(CMD_ARM_ABS, 6, 1000, 30, 905, 1'b0);  // far past, aligned to grid
    send_request(CMD_ARM_ABS, 7, 1000, 0, 400, 1'b0);   // one-shot past becomes now
    send_request(CMD_ARM_ABS, 8, 1000, 30, 980, 1'b0);  // past but within one period
    send_request(CMD_ARM_ABS, 9, 1000, 30, 1200, 1'b0);
    send_request(CMD_ARM_ABS, 10, 10, 2000, 0, 1'b0);   // period above now
    send_request(CMD_POLL, 0, 1000);
  endtask

  task automatic test_poll_order();
    for (int i = 15; i >= 11; i--) send_request(CMD_ARM_REL, 4'(i), 2000, 10, 0, 1'b0);
    send_request(CMD_ARM_ABS, 12, 2000, 7, 2010, 1'b0);
    send_request(CMD_POLL, 0, 2305);
  endtask

  task automatic test_time_extremes();
    send_request(CMD_ARM_REL, 0, TMAX - 2, TMAX, 0, 1'b1);  // saturates
    send_request(CMD_QUERY, 0, TMAX - 2);
    send_request(CMD_ARM_REL, 1, TMAX - 5, 4, 0, 1'b1);
    send_request(CMD_POLL, 0, TMAX - 1);                     // rearm overflows
    send_request(CMD_ARM_ABS, 2, TMAX, TMAX, TMAX, 1'b1);
    send_request(CMD_POLL, 0, TMAX);
    for (int i = 0; i < SLOTS; i++) send_request(CMD_CANCEL, 4'(i), 0);
    send_request(CMD_POLL, 0, 0);
  endtask

  task automatic test_random(int count);
    int pick;
    logic [63:0] ival;
    logic [63:0] st;
    clock_ms = 10000;
    for (int n = 0; n < count; n++) begin
      if (n > count - 60) idle_enable = 1'b0;
      clock_ms = clock_ms + $urandom_range(0, 30);
      if ($urandom_range(0, 19) == 0) clock_ms = rand_time();
      if (clock_ms > TMAX) clock_ms = 10000;
      pick = $urandom_range(0, 99);
      ival = $urandom_range(0, 60);
      if ($urandom_range(0, 9) == 0) ival = 0;
      else if ($urandom_range(0, 9) == 0) ival = rand_time();
      st = clock_ms - 200 + $urandom_range(0, 400);
      if ($urandom_range(0, 9) == 0) st = rand_time();
      if (pick < 30)
        send_request(CMD_POLL, 4'($urandom), clock_ms);
      else if (pick < 55)
        send_request(CMD_ARM_REL, 4'($urandom), clock_ms, ival, rand_time(), 1'($urandom));
      else if (pick < 75)
        send_request(CMD_ARM_ABS, 4'($urandom), clock_ms, ival, st, 1'($urandom));
      else if (pick < 85)
        send_request(CMD_CANCEL, 4'($urandom), clock_ms);
      else if (pick < 97)
        send_request(CMD_QUERY, 4'($urandom), clock_ms);
      else
        send_request(3'($urandom_range(5, 7)), 4'($urandom), clock_ms);
    end
    start <= 1'b0;
  endtask

  initial begin
    int guard;
    for (int i = 0; i < SLOTS; i++) begin
      slot_deadline[i] = 0; slot_period[i] = 0; slot_armed[i] = 0; slot_order[i] = 0;
    end
    order_counter = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_commands();
    test_absolute_arm();
    test_poll_order();
    test_time_extremes();
    test_random(210);
    guard = 0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;
    $display("%0d requests sent, %0d results checked (%0d timer fires), %0d mismatches",
             requests_sent, results_seen, fires_seen, mismatches);
    $display("covered all commands, time extremes, grid alignment and tie order");
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #30ms;
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
rtl/ptq_pkg.sv
rtl/ptq_div.sv
rtl/ptq_cell.sv
rtl/periodic_timer_queue_top.sv
tb/periodic_timer_queue_top_tb.sv
